// ----- hw/rtl/cwd_pkg.sv -----
// Shared types and constants for the CRC-8 word deframer.
// Used by cwd_crc8_step and crc8_word_deframer_top; depends on nothing else.
package cwd_pkg;

  // CRC-8: polynomial x^8 + x^5 + x^4 + 1, MSB first, no final XOR.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Default clamp for the word count of one transfer.
  localparam int MAX_WORDS_DEF = 6;

  // Field widths of the stream items.
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 3;
  localparam int WORD_W  = 16;

  // Position of the next byte within a three-byte group.
  typedef enum logic [1:0] {
    PH_HIGH = 2'd0,
    PH_LOW  = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

endpackage

// ----- hw/rtl/cwd_crc8_step.sv -----
// One byte-wide step of the CRC-8 (polynomial 0x31, MSB first).
// Depends on cwd_pkg for the polynomial constant.
module cwd_crc8_step
  import cwd_pkg::*;
(
  input  logic [7:0] crc_in,
  input  logic [7:0] data_in,
  output logic [7:0] crc_out
);

  // Eight shift steps over the byte, unrolled into one XOR network.
  always_comb begin
    logic [7:0] c;
    c = crc_in ^ data_in;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

// ----- hw/rtl/crc8_word_deframer_top.sv -----
// Top level of the CRC-8 word deframer: byte stream in, checked words out.
// Depends on cwd_pkg and cwd_crc8_step.
//
// The block takes one received byte per item and groups every three bytes
// into a big-endian 16-bit word and its CRC-8 (polynomial 0x31, init 0xFF).
// The third byte of a group produces one result item with the word, a CRC
// pass flag, the word index, a sticky transfer error flag and tlast on the
// final expected word; the first two bytes produce nothing. A byte with the
// start flag opens a new transfer and loads its word count (0 is taken as
// 1, counts above MAX_WORDS are clamped); bytes after the final word are
// dropped until the next start. Each item passes through a single
// byte-wide CRC step of logic between the input and the output register,
// so the block accepts one byte every clock cycle as long as the output
// side keeps taking results.
module crc8_word_deframer_top
  import cwd_pkg::*;
#(
  parameter int MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [10:8] words_expected, rest zero
  input  logic        in_tuser,   // [0] start_req

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] data_word, [18:16] word_index, rest zero
  output logic [1:0]  out_tuser,  // [0] crc_ok, [1] transfer_error
  output logic        out_tlast   // last word of the transfer
);

  // Deframing state.
  phase_t               phase_r, phase_nxt;
  logic [BYTE_W-1:0]    high_r, high_nxt;
  logic [BYTE_W-1:0]    low_r, low_nxt;
  logic [7:0]           crc_r, crc_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [COUNT_W-1:0]   expect_r, expect_nxt;
  logic                 err_r, err_nxt;

  // Output register.
  logic                 ovalid_r, ovalid_nxt;
  logic [WORD_W-1:0]    oword_r, oword_nxt;
  logic [COUNT_W-1:0]   oindex_r, oindex_nxt;
  logic                 ook_r, ook_nxt;
  logic                 oerr_r, oerr_nxt;
  logic                 olast_r, olast_nxt;

  // Input fields and working values.
  logic                 accept;
  logic [BYTE_W-1:0]    rx_byte;
  logic                 start_req;
  logic [COUNT_W-1:0]   want;
  logic [COUNT_W-1:0]   want_clamped;
  phase_t               phase_eff;
  logic [COUNT_W-1:0]   count_eff;
  logic [COUNT_W-1:0]   expect_eff;
  logic                 err_eff;
  logic                 drop;
  logic                 emit;
  logic [7:0]           crc_seed;
  logic [7:0]           crc_step;
  logic                 crc_match;

  assign rx_byte   = in_tdata[7:0];
  assign want      = in_tdata[10:8];
  assign start_req = in_tuser;

  // A new byte enters whenever the output register is empty or being drained.
  assign in_tready = !ovalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Clamp the requested word count to the supported range.
  always_comb begin
    want_clamped = want;
    if (want == '0) begin
      want_clamped = COUNT_W'(1);
    end else if (int'(want) > MAX_WORDS) begin
      want_clamped = COUNT_W'(MAX_WORDS);
    end
  end

  // State as seen by this byte, after a start flag has taken effect.
  always_comb begin
    if (start_req) begin
      phase_eff  = PH_HIGH;
      count_eff  = '0;
      expect_eff = want_clamped;
      err_eff    = 1'b0;
    end else begin
      phase_eff  = phase_r;
      count_eff  = count_r;
      expect_eff = expect_r;
      err_eff    = err_r;
    end
  end

  // Bytes past the final word of a transfer are dropped.
  assign drop = !start_req && (count_r >= expect_r);

  // The first byte of a group restarts the CRC, the second continues it.
  assign crc_seed  = (phase_eff == PH_LOW) ? crc_r : CRC_INIT;
  assign crc_match = (crc_r == rx_byte);

  cwd_crc8_step u_crc (
    .crc_in  (crc_seed),
    .data_in (rx_byte),
    .crc_out (crc_step)
  );

  // Next state of the deframer.
  always_comb begin
    phase_nxt  = phase_r;
    high_nxt   = high_r;
    low_nxt    = low_r;
    crc_nxt    = crc_r;
    count_nxt  = count_r;
    expect_nxt = expect_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    if (accept && !drop) begin
      count_nxt  = count_eff;
      expect_nxt = expect_eff;
      err_nxt    = err_eff;
      case (phase_eff)
        PH_LOW: begin
          low_nxt   = rx_byte;
          crc_nxt   = crc_step;
          phase_nxt = PH_CRC;
        end
        PH_CRC: begin
          emit      = 1'b1;
          err_nxt   = err_eff | ~crc_match;
          count_nxt = count_eff + COUNT_W'(1);
          crc_nxt   = CRC_INIT;
          phase_nxt = PH_HIGH;
        end
        default: begin
          high_nxt  = rx_byte;
          crc_nxt   = crc_step;
          phase_nxt = PH_LOW;
        end
      endcase
    end
  end

  // Result item for the third byte of a group.
  always_comb begin
    ovalid_nxt = ovalid_r && !out_tready;
    oword_nxt  = oword_r;
    oindex_nxt = oindex_r;
    ook_nxt    = ook_r;
    oerr_nxt   = oerr_r;
    olast_nxt  = olast_r;
    if (emit) begin
      ovalid_nxt = 1'b1;
      oword_nxt  = {high_r, low_r};
      oindex_nxt = count_eff;
      ook_nxt    = crc_match;
      oerr_nxt   = err_eff | ~crc_match;
      olast_nxt  = ({1'b0, count_eff} + {1'b0, COUNT_W'(1)}) == {1'b0, expect_eff};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HIGH;
      crc_r    <= CRC_INIT;
      count_r  <= '0;
      expect_r <= COUNT_W'(1);
      err_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      crc_r    <= crc_nxt;
      count_r  <= count_nxt;
      expect_r <= expect_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    high_r   <= high_nxt;
    low_r    <= low_nxt;
    oword_r  <= oword_nxt;
    oindex_r <= oindex_nxt;
    ook_r    <= ook_nxt;
    oerr_r   <= oerr_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, oindex_r, oword_r};
  assign out_tuser  = {oerr_r, ook_r};
  assign out_tlast  = olast_r;

endmodule
